FILE: src/rfdt_pkg.sv
// Shared types, constants and helper functions of the ring fault diagnosis table.
package rfdt_pkg;

   // Sizes of the node table and of the per-tester view counters.
   localparam int MAX_NODES = 16;
   localparam int NODE_BITS = 4;
   localparam int COUNT_BITS = 16;
   localparam int ENTRY_BITS = 2 * NODE_BITS;
   localparam int VIEW_DEPTH = MAX_NODES * MAX_NODES;
   localparam int RING_BITS = NODE_BITS + 1;
   localparam int RING_MIN = 2;
   localparam int RING_MAX = (MAX_NODES < 16) ? MAX_NODES : 16;

   // Event kinds; the last code is undefined and is answered as a bad node.
   localparam logic [1:0] KIND_TEST = 2'd0;
   localparam logic [1:0] KIND_FAULT = 2'd1;
   localparam logic [1:0] KIND_RECOVER = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [2:0] STAT_TESTED = 3'd0;
   localparam logic [2:0] STAT_SKIPPED = 3'd1;
   localparam logic [2:0] STAT_FAULT_SET = 3'd2;
   localparam logic [2:0] STAT_FAULT_REJ = 3'd3;
   localparam logic [2:0] STAT_RECOVERED = 3'd4;
   localparam logic [2:0] STAT_BAD_NODE = 3'd5;

   // One input event.
   typedef struct packed {
      logic [1:0] kind;
      logic [NODE_BITS-1:0] node;
   } req_type;

   // One result of an event.
   typedef struct packed {
      logic [2:0] status;
      logic [NODE_BITS-1:0] tester;
      logic [NODE_BITS-1:0] tested;
      logic tested_faulty;
      logic [COUNT_BITS-1:0] event_count;
      logic all_others_faulty;
      logic last;
   } rsp_type;

   // Each node knows its own view entry from the start.
   function automatic logic [VIEW_DEPTH-1:0] diag_mask();
      logic [VIEW_DEPTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         mask[i * MAX_NODES + i] = 1'b1;
      end
      return mask;
   endfunction

   // Next node along the ring of the given size.
   function automatic logic [NODE_BITS-1:0] ring_next(input logic [NODE_BITS-1:0] x,
                                                      input logic [RING_BITS-1:0] n);
      logic [RING_BITS-1:0] nxt;
      nxt = {1'b0, x} + RING_BITS'(1);
      if (nxt == n) begin
         return '0;
      end
      return nxt[NODE_BITS-1:0];
   endfunction

endpackage

FILE: src/rfdt_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module rfdt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read sees data written at earlier edges.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ring_fault_diagnosis_table.sv
// Ring fault diagnosis table: node fault flags and per-tester view counters.
// Fault, recovery, rejected, skipped and bad events: one result, shown in the cycle after the transfer; busy stays low.
// Test round: one successor per cycle through a counter RAM read-modify-write; busy stays high
// while the round walks, and the round ends at the first fault-free successor or on wrap-around.
// Results cannot be stalled; each is shown for one cycle with rsp_strobe.
// Synchronous reset clears all fault flags and all view marks but each node's own at once; no clearing pass is needed.
module ring_fault_diagnosis_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  rfdt_pkg::req_type         req_item,
   output logic                      rsp_strobe,
   output rfdt_pkg::rsp_type         rsp_item,
   input  logic                      csr_we,
   input  logic [rfdt_pkg::RING_BITS-1:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;
   logic [rfdt_pkg::RING_BITS-1:0] node_count_ff;
   logic [rfdt_pkg::MAX_NODES-1:0] faulty_ff, faulty_in;
   logic [rfdt_pkg::VIEW_DEPTH-1:0] known_ff, known_in;
   logic [rfdt_pkg::NODE_BITS-1:0] tester_ff, tester_in;
   logic [rfdt_pkg::NODE_BITS-1:0] succ_ff, succ_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rfdt_pkg::rsp_type rsp_ff, rsp_in;

   logic [rfdt_pkg::RING_BITS-1:0] ring_n;
   logic accept;
   logic [rfdt_pkg::NODE_BITS-1:0] fault_idx;
   logic sel_faulty;
   logic [rfdt_pkg::ENTRY_BITS-1:0] cur_entry;
   logic [rfdt_pkg::ENTRY_BITS-1:0] rd_addr;
   logic [rfdt_pkg::COUNT_BITS-1:0] cnt_rd;
   logic [rfdt_pkg::COUNT_BITS-1:0] cnt_new;
   logic cnt_wr;
   logic [rfdt_pkg::NODE_BITS-1:0] succ_next;
   logic cur_known;
   logic wrapped;

   // Effective ring size from the configured node count.
   always_comb begin
      if (node_count_ff < rfdt_pkg::RING_BITS'(rfdt_pkg::RING_MIN)) begin
         ring_n = rfdt_pkg::RING_BITS'(rfdt_pkg::RING_MIN);
      end else if (node_count_ff > rfdt_pkg::RING_BITS'(rfdt_pkg::RING_MAX)) begin
         ring_n = rfdt_pkg::RING_BITS'(rfdt_pkg::RING_MAX);
      end else begin
         ring_n = node_count_ff;
      end
   end

   assign busy = (state_ff == ST_WALK);
   assign accept = start && !busy;

   // One fault flag read per cycle: the event's node when idle, the successor while walking.
   assign fault_idx = (state_ff == ST_WALK) ? succ_ff : req_item.node;
   assign sel_faulty = faulty_ff[fault_idx];

   assign cur_entry = {tester_ff, succ_ff};
   assign cur_known = known_ff[cur_entry];
   assign succ_next = rfdt_pkg::ring_next(succ_ff, ring_n);
   assign wrapped = (succ_next == tester_ff);

   // The read for the next successor is issued while the current one is written back.
   always_comb begin
      if (state_ff == ST_WALK) begin
         rd_addr = {tester_ff, succ_next};
      end else begin
         rd_addr = {req_item.node, rfdt_pkg::ring_next(req_item.node, ring_n)};
      end
   end

   // Parity-coded counter update: odd means faulty, even means fault-free.
   always_comb begin
      if (!cur_known) begin
         cnt_new = {{(rfdt_pkg::COUNT_BITS-1){1'b0}}, sel_faulty};
      end else if (cnt_rd[0] != sel_faulty) begin
         cnt_new = cnt_rd + rfdt_pkg::COUNT_BITS'(1);
      end else begin
         cnt_new = cnt_rd;
      end
   end

   // Event decode and walk control.
   always_comb begin
      state_in = state_ff;
      faulty_in = faulty_ff;
      known_in = known_ff;
      tester_in = tester_ff;
      succ_in = succ_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = '0;
      cnt_wr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_in.tester = req_item.node;
               rsp_in.last = 1'b1;
               if (req_item.kind == rfdt_pkg::KIND_UNUSED ||
                   {1'b0, req_item.node} >= ring_n) begin
                  rsp_in.status = rfdt_pkg::STAT_BAD_NODE;
               end else if (req_item.kind == rfdt_pkg::KIND_FAULT) begin
                  if (sel_faulty) begin
                     rsp_in.status = rfdt_pkg::STAT_FAULT_REJ;
                  end else begin
                     rsp_in.status = rfdt_pkg::STAT_FAULT_SET;
                     faulty_in[req_item.node] = 1'b1;
                  end
               end else if (req_item.kind == rfdt_pkg::KIND_RECOVER) begin
                  rsp_in.status = rfdt_pkg::STAT_RECOVERED;
                  faulty_in[req_item.node] = 1'b0;
               end else if (sel_faulty) begin
                  rsp_in.status = rfdt_pkg::STAT_SKIPPED;
               end else begin
                  // Fault-free tester: start the walk; the results come from the walk.
                  rsp_strobe_in = 1'b0;
                  rsp_in = '0;
                  tester_in = req_item.node;
                  succ_in = rfdt_pkg::ring_next(req_item.node, ring_n);
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cnt_wr = 1'b1;
            known_in[cur_entry] = 1'b1;
            rsp_strobe_in = 1'b1;
            rsp_in.status = rfdt_pkg::STAT_TESTED;
            rsp_in.tester = tester_ff;
            rsp_in.tested = succ_ff;
            rsp_in.tested_faulty = sel_faulty;
            rsp_in.event_count = cnt_new;
            if (!sel_faulty) begin
               rsp_in.last = 1'b1;
               state_in = ST_IDLE;
            end else if (wrapped) begin
               rsp_in.last = 1'b1;
               rsp_in.all_others_faulty = 1'b1;
               state_in = ST_IDLE;
            end else begin
               succ_in = succ_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         node_count_ff <= rfdt_pkg::RING_BITS'(16);
         faulty_ff <= '0;
         known_ff <= rfdt_pkg::diag_mask();
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         faulty_ff <= faulty_in;
         known_ff <= known_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tester_ff <= tester_in;
      succ_ff <= succ_in;
      rsp_ff <= rsp_in;
   end

   // View counters, one entry per tester and tested node.
   rfdt_ram #(
      .WIDTH(rfdt_pkg::COUNT_BITS),
      .DEPTH(rfdt_pkg::VIEW_DEPTH)
   ) u_view_ram (
      .clock  (clock),
      .wr_en  (cnt_wr),
      .wr_addr(cur_entry),
      .wr_data(cnt_new),
      .rd_addr(rd_addr),
      .rd_data(cnt_rd)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

FILE: src/rfdt_checker.sv
// Port-level checks of the ring fault diagnosis table, bound to the top level.
module rfdt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input rfdt_pkg::req_type         req_item,
   input logic                      rsp_strobe,
   input rfdt_pkg::rsp_type         rsp_item
);

   // Every accepted transfer gives a first result; a test round gives it later than the other events.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##[1:2] rsp_strobe)
      else $error("no result after an accepted transfer");

   // A round that is not finished keeps the block busy and keeps delivering.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("unfinished round while not busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |=> rsp_strobe)
      else $error("gap inside a test round");

   // Only tested results carry test data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != rfdt_pkg::STAT_TESTED |->
         rsp_item.last && !rsp_item.tested_faulty && !rsp_item.all_others_faulty &&
         rsp_item.event_count == '0)
      else $error("non-test result carries test data");

   // All-others-faulty closes a round on a faulty, odd counter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.all_others_faulty |->
         rsp_item.last && rsp_item.tested_faulty && rsp_item.event_count[0])
      else $error("bad all-others-faulty result");

endmodule

bind ring_fault_diagnosis_table rfdt_checker u_rfdt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item  (rsp_item)
);

FILE: tb/ring_fault_diagnosis_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ring fault diagnosis table: directed table, then random phases.
module ring_fault_diagnosis_table_tb;
   import rfdt_pkg::*;

   localparam int MAX_GAP = 14;
   localparam int IDLE_SETTLE = 4;
   localparam int END_SETTLE = 40;
   localparam int CYCLE_LIMIT = 200000;

   // One row of the directed table: either a ring size write or an event transfer.
   typedef struct packed {
      logic csr_write;
      logic [RING_BITS-1:0] ring_cfg;
      req_type ev;
      logic typed;
      rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_we;
   logic [RING_BITS-1:0] csr_wdata;

   // Predicted state of the block.
   logic [RING_BITS-1:0] model_ring_cfg;
   logic model_faulty [MAX_NODES];
   logic [COUNT_BITS-1:0] model_view_count [VIEW_DEPTH];
   logic model_view_known [VIEW_DEPTH];

   // Reports of the latest event and the reports still owed by the block.
   rsp_type event_reports [MAX_NODES];
   int event_report_len;
   rsp_type pending_reports [$];

   dir_row_type dir_rows [$];
   int mismatch_count;
   int cycle_count;

   ring_fault_diagnosis_table u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Effective ring size after clamping of the register value.
   function automatic int ring_size();
      if (model_ring_cfg < RING_BITS'(RING_MIN)) begin
         return RING_MIN;
      end
      if (model_ring_cfg > RING_BITS'(RING_MAX)) begin
         return RING_MAX;
      end
      return int'(model_ring_cfg);
   endfunction

   function automatic rsp_type report(input logic [2:0] status, input int tester, input int tested,
                                      input logic tf, input int cnt, input logic aof,
                                      input logic last);
      rsp_type r;
      r.status = status;
      r.tester = tester[NODE_BITS-1:0];
      r.tested = tested[NODE_BITS-1:0];
      r.tested_faulty = tf;
      r.event_count = cnt[COUNT_BITS-1:0];
      r.all_others_faulty = aof;
      r.last = last;
      return r;
   endfunction

   function automatic req_type make_event(input logic [1:0] kind, input int node);
      req_type ev;
      ev.kind = kind;
      ev.node = node[NODE_BITS-1:0];
      return ev;
   endfunction

   function automatic dir_row_type ev_row(input logic [1:0] kind, input int node,
                                          input logic typed, input rsp_type want);
      dir_row_type row;
      row = '0;
      row.ev = make_event(kind, node);
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input int value);
      dir_row_type row;
      row = '0;
      row.csr_write = 1'b1;
      row.ring_cfg = value[RING_BITS-1:0];
      return row;
   endfunction

   // Diagnosis of one event: updates the predicted tables and fills event_reports.
   task automatic diagnose_event(input req_type ev);
      int ring;
      int step;
      int succ;
      int idx;
      logic found_faulty;
      logic [COUNT_BITS-1:0] cnt;
      logic wrapped;
      ring = ring_size();
      event_report_len = 1;
      if (ev.kind == KIND_UNUSED || int'(ev.node) >= ring) begin
         event_reports[0] = report(STAT_BAD_NODE, ev.node, 0, 0, 0, 0, 1);
      end else if (ev.kind == KIND_FAULT) begin
         if (model_faulty[ev.node]) begin
            event_reports[0] = report(STAT_FAULT_REJ, ev.node, 0, 0, 0, 0, 1);
         end else begin
            model_faulty[ev.node] = 1'b1;
            event_reports[0] = report(STAT_FAULT_SET, ev.node, 0, 0, 0, 0, 1);
         end
      end else if (ev.kind == KIND_RECOVER) begin
         model_faulty[ev.node] = 1'b0;
         event_reports[0] = report(STAT_RECOVERED, ev.node, 0, 0, 0, 0, 1);
      end else if (model_faulty[ev.node]) begin
         event_reports[0] = report(STAT_SKIPPED, ev.node, 0, 0, 0, 0, 1);
      end else begin
         // Walk the successors until the first healthy one; odd counts mean faulty.
         event_report_len = 0;
         for (step = 1; step < ring; step++) begin
            succ = (int'(ev.node) + step) % ring;
            idx = int'(ev.node) * MAX_NODES + succ;
            found_faulty = model_faulty[succ];
            cnt = model_view_count[idx];
            if (!model_view_known[idx]) begin
               cnt = found_faulty ? COUNT_BITS'(1) : '0;
            end else if (cnt[0] != found_faulty) begin
               cnt = cnt + 1'b1;
            end
            model_view_count[idx] = cnt;
            model_view_known[idx] = 1'b1;
            wrapped = found_faulty && (step == ring - 1);
            event_reports[event_report_len] = report(STAT_TESTED, ev.node, succ, found_faulty,
                                                     cnt, wrapped, !found_faulty || wrapped);
            event_report_len++;
            if (!found_faulty) begin
               break;
            end
         end
      end
   endtask

   // Drive one event, wait for its transfer and queue what it should produce.
   task automatic send_event(input req_type ev, input logic typed, input rsp_type want,
                             input int gap);
      int i;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= ev;
      do @(posedge clock); while (busy);
      diagnose_event(ev);
      if (typed) begin
         pending_reports.push_back(want);
      end else begin
         for (i = 0; i < event_report_len; i++) begin
            pending_reports.push_back(event_reports[i]);
         end
      end
   endtask

   // Hold off the sender until the block has delivered everything it owes.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_ring_size(input logic [RING_BITS-1:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      model_ring_cfg = value;
      @(posedge clock);
   endtask

   // Mostly events inside the ring, with some out-of-ring nodes and undefined kinds.
   function automatic req_type random_event();
      req_type ev;
      int pick;
      pick = $urandom_range(0, 99);
      ev.node = NODE_BITS'($urandom_range(0, ring_size() - 1));
      if (pick < 6) begin
         ev.kind = 2'($urandom_range(0, 3));
         ev.node = NODE_BITS'($urandom_range(0, MAX_NODES - 1));
      end else if (pick < 55) begin
         ev.kind = KIND_TEST;
      end else if (pick < 82) begin
         ev.kind = KIND_FAULT;
      end else begin
         ev.kind = KIND_RECOVER;
      end
      return ev;
   endfunction

   // One random phase at a given ring size; sometimes it first fails every node but one.
   task automatic run_phase(input logic [RING_BITS-1:0] ring_cfg, input int count);
      int k;
      int gap_max;
      int survivor;
      write_ring_size(ring_cfg);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      if ($urandom_range(0, 1) == 1) begin
         survivor = $urandom_range(0, ring_size() - 1);
         for (k = 0; k < ring_size(); k++) begin
            if (k != survivor) begin
               send_event(make_event(KIND_FAULT, k), 1'b0, '0, $urandom_range(0, gap_max));
            end
         end
         send_event(make_event(KIND_TEST, survivor), 1'b0, '0, $urandom_range(0, gap_max));
      end
      for (k = 0; k < count; k++) begin
         send_event(random_event(), 1'b0, '0, $urandom_range(0, gap_max));
         if ($urandom_range(0, 24) == 0) begin
            wait_idle();
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Each strobed result is matched against the oldest outstanding report.
   always @(posedge clock) begin : check_reports
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none actual %h",
                     $time, rsp_item);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("status", want.status, rsp_item.status);
            check_field("tester", want.tester, rsp_item.tester);
            check_field("tested", want.tested, rsp_item.tested);
            check_field("tested_faulty", want.tested_faulty, rsp_item.tested_faulty);
            check_field("event_count", want.event_count, rsp_item.event_count);
            check_field("all_others_faulty", want.all_others_faulty,
                        rsp_item.all_others_faulty);
            check_field("last", want.last, rsp_item.last);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ring_fault_diagnosis_table regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int r;
      int p;
      logic [RING_BITS-1:0] phase_cfg [10];
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = RING_BITS'(16);
      mismatch_count = 0;
      cycle_count = 0;
      model_ring_cfg = RING_BITS'(16);
      for (r = 0; r < MAX_NODES; r++) begin
         model_faulty[r] = 1'b0;
      end
      for (r = 0; r < VIEW_DEPTH; r++) begin
         model_view_count[r] = '0;
         model_view_known[r] = (r / MAX_NODES) == (r % MAX_NODES);
      end

      // Directed table: fresh ring of 16, repeated fault and recovery, wrap-around,
      // a two-node ring where the other node is faulty, and clamped ring sizes.
      dir_rows.push_back(ev_row(KIND_TEST, 0, 1, report(STAT_TESTED, 0, 1, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_UNUSED, 15, 1, report(STAT_BAD_NODE, 15, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 15, 1, report(STAT_TESTED, 15, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_FAULT, 1, 1, report(STAT_FAULT_SET, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_FAULT, 1, 1, report(STAT_FAULT_REJ, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 1, 1, report(STAT_SKIPPED, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 0, 0, '0));
      dir_rows.push_back(ev_row(KIND_RECOVER, 1, 1, report(STAT_RECOVERED, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_RECOVER, 1, 1, report(STAT_RECOVERED, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 0, 0, '0));
      dir_rows.push_back(ev_row(KIND_FAULT, 15, 1, report(STAT_FAULT_SET, 15, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 14, 0, '0));
      dir_rows.push_back(csr_row(2));
      dir_rows.push_back(ev_row(KIND_FAULT, 2, 1, report(STAT_BAD_NODE, 2, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 15, 1, report(STAT_BAD_NODE, 15, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_FAULT, 1, 1, report(STAT_FAULT_SET, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(ev_row(KIND_TEST, 0, 0, '0));
      dir_rows.push_back(ev_row(KIND_RECOVER, 1, 1, report(STAT_RECOVERED, 1, 0, 0, 0, 0, 1)));
      dir_rows.push_back(csr_row(0));
      dir_rows.push_back(ev_row(KIND_TEST, 1, 0, '0));
      dir_rows.push_back(csr_row(31));
      dir_rows.push_back(ev_row(KIND_TEST, 13, 0, '0));
      dir_rows.push_back(csr_row(1));
      dir_rows.push_back(ev_row(KIND_RECOVER, 15, 1, report(STAT_BAD_NODE, 15, 0, 0, 0, 0, 1)));
      dir_rows.push_back(csr_row(16));
      dir_rows.push_back(ev_row(KIND_RECOVER, 15, 1, report(STAT_RECOVERED, 15, 0, 0, 0, 0, 1)));

      phase_cfg = '{5'd16, 5'd5, 5'd2, 5'd31, 5'd0, 5'd9, 5'd17, 5'd1, 5'd3, 5'd16};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].csr_write) begin
            write_ring_size(dir_rows[i].ring_cfg);
         end else begin
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want,
                       $urandom_range(0, MAX_GAP));
         end
      end

      for (p = 0; p < 10; p++) begin
         run_phase(phase_cfg[p], 25);
      end

      // Let the last rounds finish, then give the block time to show anything stray.
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_reports.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("ring_fault_diagnosis_table regression: pass");
      end else begin
         $display("ring_fault_diagnosis_table regression: fail");
      end
      $finish;
   end

endmodule
